// ----- sv/delta_list_timer_queue_top_defines.svh -----
// Assertion macros used by the checker file of the timer queue.
`ifndef DELTA_LIST_TIMER_QUEUE_TOP_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_TOP_DEFINES_SVH

// Checked property that is ignored while reset is high.
`define DLTQ_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("timer queue check failed");

// Checked property that also holds while reset is high.
`define DLTQ_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("timer queue check failed");

`endif

// ----- sv/dltq_pkg.sv -----
// Shared constants and types of the delta list timer queue.
package dltq_pkg;
   localparam int NUM_TIMERS = 16;
   localparam int MAX_FIRES = 64;
   localparam int TIME_W = 32;
   localparam int ID_W = 4;
   localparam int KIND_W = 2;
   localparam int SLOT_W = $clog2(NUM_TIMERS + 1);
   localparam int IDX_W = $clog2(NUM_TIMERS);
   localparam int CNT_W = $clog2(MAX_FIRES + 1);
   localparam int BUF_AW = (MAX_FIRES > 1) ? $clog2(MAX_FIRES) : 1;
   localparam int BUF_DEPTH = MAX_FIRES;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

   localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(NUM_TIMERS);

   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_ADD_OK = 2'd0;
   localparam kind_type KIND_ADD_REFUSED = 2'd1;
   localparam kind_type KIND_FIRED = 2'd2;

   typedef struct packed {
      logic              is_tick;
      logic [ID_W-1:0]   timer_id;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] now_time;
   } cmd_type;
endpackage

// ----- sv/dltq_front.sv -----
// Front end: accepts requests, classifies them and queues them for the engine.
module dltq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          mode,
   input  logic [dltq_pkg::ID_W-1:0]     timer_id,
   input  logic [dltq_pkg::TIME_W-1:0]   delay,
   input  logic [dltq_pkg::TIME_W-1:0]   period,
   input  logic [dltq_pkg::TIME_W-1:0]   now_time,
   output logic                          cmd_valid,
   output dltq_pkg::cmd_type             cmd,
   input  logic                          cmd_take
);
   import dltq_pkg::*;

   cmd_type              queue_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff;
   logic [FIFO_AW-1:0]   rd_ptr_ff;
   logic [FIFO_CW-1:0]   count_ff;
   logic                 do_push;
   logic                 do_pop;
   cmd_type              new_cmd;

   assign full = (count_ff == FIFO_CW'(FIFO_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd = queue_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = cmd_take && cmd_valid;

   always_comb begin
      new_cmd.is_tick = mode;
      new_cmd.timer_id = timer_id;
      new_cmd.delay = delay;
      new_cmd.period = period;
      new_cmd.now_time = now_time;
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 :
                         wr_ptr_ff + FIFO_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 :
                         rd_ptr_ff + FIFO_AW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + FIFO_CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - FIFO_CW'(1);
         end
      end
   end
endmodule

// ----- sv/dltq_engine.sv -----
// Back end: walks the delta list, fires due timers and delivers the results.
module dltq_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  dltq_pkg::cmd_type             cmd,
   output logic                          cmd_take,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dltq_pkg::TIME_W-1:0]   csr_start_time,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [dltq_pkg::KIND_W-1:0]   rsp_kind,
   output logic [dltq_pkg::ID_W-1:0]     rsp_which_timer,
   output logic [dltq_pkg::TIME_W-1:0]   rsp_fire_time,
   output logic                          rsp_last,
   output logic                          rsp_overflow
);
   import dltq_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_ADD_CHK  = 9'b000000010,
      ST_WALK     = 9'b000000100,
      ST_LINK     = 9'b000001000,
      ST_FIX      = 9'b000010000,
      ST_TICK_POP = 9'b000100000,
      ST_TICK_END = 9'b001000000,
      ST_EMIT_RD  = 9'b010000000,
      ST_EMIT_WR  = 9'b100000000
   } state_type;

   state_type           state_ff;
   cmd_type             cmd_ff;
   logic [SLOT_W-1:0]   head_ff;
   logic [NUM_TIMERS-1:0] active_ff;
   logic [TIME_W-1:0]   ref_ff;
   logic [SLOT_W-1:0]   link_ff [NUM_TIMERS];
   logic [TIME_W-1:0]   delta_ff [NUM_TIMERS];
   logic [TIME_W-1:0]   period_ff [NUM_TIMERS];
   logic [SLOT_W-1:0]   ins_slot_ff;
   logic [TIME_W-1:0]   ins_t_ff;
   logic [SLOT_W-1:0]   prev_ff;
   logic [SLOT_W-1:0]   cur_ff;
   logic [SLOT_W-1:0]   guard_ff;
   logic                from_tick_ff;
   logic [TIME_W-1:0]   elapsed_ff;
   logic [CNT_W-1:0]    n_ff;
   logic [CNT_W-1:0]    emit_ff;
   logic                ovf_ff;
   kind_type            res_kind_ff;
   logic [TIME_W-1:0]   res_time_ff;
   logic [ID_W-1:0]     buf_mem [BUF_DEPTH];
   logic [ID_W-1:0]     buf_q_ff;
   logic                out_valid_ff;
   kind_type            out_kind_ff;
   logic [ID_W-1:0]     out_id_ff;
   logic [TIME_W-1:0]   out_time_ff;
   logic                out_last_ff;
   logic                out_ovf_ff;

   logic [SLOT_W-1:0]   rd_slot;
   logic [IDX_W-1:0]    rd_idx;
   logic                rd_ok;
   logic [TIME_W-1:0]   rd_delta;
   logic [SLOT_W-1:0]   rd_link;
   logic [TIME_W-1:0]   rd_period;
   logic [IDX_W-1:0]    id_idx;
   logic                id_ok;
   logic                due;
   logic [TIME_W-1:0]   elapsed_left;
   logic                buf_we;
   logic [BUF_AW-1:0]   buf_wa;
   logic [ID_W-1:0]     buf_wd;
   logic                out_free;
   logic                emit_last;

   assign rd_slot = (state_ff == ST_WALK || state_ff == ST_FIX) ? cur_ff : head_ff;
   assign rd_idx = rd_slot[IDX_W-1:0];
   assign rd_ok = (rd_slot < SLOT_NONE);
   assign rd_delta = delta_ff[rd_idx];
   assign rd_link = link_ff[rd_idx];
   assign rd_period = period_ff[rd_idx];
   assign id_idx = IDX_W'(cmd_ff.timer_id);
   assign id_ok = ({{SLOT_W{1'b0}}, cmd_ff.timer_id} < {{ID_W{1'b0}}, SLOT_NONE});
   assign due = rd_ok && (rd_delta <= elapsed_ff);
   assign elapsed_left = elapsed_ff - rd_delta;
   assign out_free = !out_valid_ff || rsp_pop;
   assign emit_last = (emit_ff == n_ff - CNT_W'(1));

   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid;
   assign csr_ready = (state_ff == ST_IDLE);

   assign rsp_empty = !out_valid_ff;
   assign rsp_kind = out_kind_ff;
   assign rsp_which_timer = out_id_ff;
   assign rsp_fire_time = out_time_ff;
   assign rsp_last = out_last_ff;
   assign rsp_overflow = out_ovf_ff;

   always_comb begin
      buf_we = 1'b0;
      buf_wa = '0;
      buf_wd = cmd_ff.timer_id;
      if (state_ff == ST_ADD_CHK) begin
         buf_we = 1'b1;
      end else if (state_ff == ST_TICK_POP && due && n_ff != CNT_W'(MAX_FIRES)) begin
         buf_we = 1'b1;
         buf_wa = n_ff[BUF_AW-1:0];
         buf_wd = ID_W'(head_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_wa] <= buf_wd;
      end
      buf_q_ff <= buf_mem[emit_ff[BUF_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_ADD_CHK: begin
            if (id_ok && !active_ff[id_idx]) begin
               period_ff[id_idx] <= cmd_ff.period;
            end
         end
         ST_LINK: begin
            link_ff[ins_slot_ff[IDX_W-1:0]] <= cur_ff;
            delta_ff[ins_slot_ff[IDX_W-1:0]] <= ins_t_ff;
         end
         ST_FIX: begin
            if (prev_ff != SLOT_NONE) begin
               link_ff[prev_ff[IDX_W-1:0]] <= ins_slot_ff;
            end
            if (rd_ok) begin
               delta_ff[rd_idx] <= rd_delta - ins_t_ff;
            end
         end
         ST_TICK_END: begin
            if (!ovf_ff && rd_ok) begin
               delta_ff[rd_idx] <= rd_delta - elapsed_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= SLOT_NONE;
         active_ff <= '0;
         ref_ff <= '0;
         out_valid_ff <= 1'b0;
         n_ff <= '0;
         emit_ff <= '0;
         ovf_ff <= 1'b0;
         from_tick_ff <= 1'b0;
      end else begin
         if (out_free) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  ref_ff <= csr_start_time;
               end
               if (cmd_valid) begin
                  cmd_ff <= cmd;
                  if (cmd.is_tick) begin
                     elapsed_ff <= cmd.now_time - ref_ff;
                     n_ff <= '0;
                     ovf_ff <= 1'b0;
                     res_kind_ff <= KIND_FIRED;
                     res_time_ff <= cmd.now_time;
                     state_ff <= ST_TICK_POP;
                  end else begin
                     state_ff <= ST_ADD_CHK;
                  end
               end
            end
            ST_ADD_CHK: begin
               n_ff <= CNT_W'(1);
               ovf_ff <= 1'b0;
               res_time_ff <= '0;
               emit_ff <= '0;
               if (id_ok && !active_ff[id_idx]) begin
                  res_kind_ff <= KIND_ADD_OK;
                  active_ff[id_idx] <= 1'b1;
                  ins_slot_ff <= SLOT_W'(id_idx);
                  ins_t_ff <= cmd_ff.now_time - ref_ff + cmd_ff.delay;
                  prev_ff <= SLOT_NONE;
                  cur_ff <= head_ff;
                  guard_ff <= '0;
                  from_tick_ff <= 1'b0;
                  state_ff <= ST_WALK;
               end else begin
                  res_kind_ff <= KIND_ADD_REFUSED;
                  state_ff <= ST_EMIT_RD;
               end
            end
            ST_WALK: begin
               if (rd_ok && rd_delta <= ins_t_ff && guard_ff < SLOT_NONE) begin
                  ins_t_ff <= ins_t_ff - rd_delta;
                  prev_ff <= cur_ff;
                  cur_ff <= rd_link;
                  guard_ff <= guard_ff + SLOT_W'(1);
               end else begin
                  if (!rd_ok) begin
                     cur_ff <= SLOT_NONE;
                  end
                  state_ff <= ST_LINK;
               end
            end
            ST_LINK: begin
               if (prev_ff == SLOT_NONE) begin
                  head_ff <= ins_slot_ff;
               end
               state_ff <= ST_FIX;
            end
            ST_FIX: begin
               emit_ff <= '0;
               state_ff <= from_tick_ff ? ST_TICK_POP : ST_EMIT_RD;
            end
            ST_TICK_POP: begin
               if (due && n_ff == CNT_W'(MAX_FIRES)) begin
                  ovf_ff <= 1'b1;
                  state_ff <= ST_TICK_END;
               end else if (due) begin
                  head_ff <= rd_link;
                  ref_ff <= ref_ff + rd_delta;
                  elapsed_ff <= elapsed_left;
                  n_ff <= n_ff + CNT_W'(1);
                  if (rd_period != '0) begin
                     ins_slot_ff <= head_ff;
                     ins_t_ff <= elapsed_left + rd_period;
                     prev_ff <= SLOT_NONE;
                     cur_ff <= rd_link;
                     guard_ff <= '0;
                     from_tick_ff <= 1'b1;
                     state_ff <= ST_WALK;
                  end else begin
                     active_ff[rd_idx] <= 1'b0;
                  end
               end else begin
                  state_ff <= ST_TICK_END;
               end
            end
            ST_TICK_END: begin
               if (!ovf_ff) begin
                  ref_ff <= cmd_ff.now_time;
               end
               emit_ff <= '0;
               state_ff <= (n_ff == '0) ? ST_IDLE : ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
               state_ff <= ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_kind_ff <= res_kind_ff;
                  out_id_ff <= buf_q_ff;
                  out_time_ff <= res_time_ff;
                  out_last_ff <= emit_last;
                  out_ovf_ff <= ovf_ff;
                  emit_ff <= emit_ff + CNT_W'(1);
                  state_ff <= emit_last ? ST_IDLE : ST_EMIT_RD;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule

// ----- sv/delta_list_timer_queue_top.sv -----
// Top level of the delta list timer queue: front end, command queue and engine.
// An add checks the identifier, walks the list to its place, links the entry and fixes the next delta.
// A tick fires the due timers one by one and walks the list anew to reinsert each periodic timer.
// Each result then leaves through the output register, which holds it until it is popped.
// Up to two requests wait in the front queue while the engine works.
// Reset is synchronous and active high; it empties the list, the command queue and the output register at once.
module delta_list_timer_queue_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_mode,
   input  logic [dltq_pkg::ID_W-1:0]     req_timer_id,
   input  logic [dltq_pkg::TIME_W-1:0]   req_delay,
   input  logic [dltq_pkg::TIME_W-1:0]   req_period,
   input  logic [dltq_pkg::TIME_W-1:0]   req_now_time,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [dltq_pkg::KIND_W-1:0]   rsp_kind,
   output logic [dltq_pkg::ID_W-1:0]     rsp_which_timer,
   output logic [dltq_pkg::TIME_W-1:0]   rsp_fire_time,
   output logic                          rsp_last,
   output logic                          rsp_overflow,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dltq_pkg::TIME_W-1:0]   csr_start_time
);
   import dltq_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   dltq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .mode      (req_mode),
      .timer_id  (req_timer_id),
      .delay     (req_delay),
      .period    (req_period),
      .now_time  (req_now_time),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   dltq_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_start_time  (csr_start_time),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_which_timer (rsp_which_timer),
      .rsp_fire_time   (rsp_fire_time),
      .rsp_last        (rsp_last),
      .rsp_overflow    (rsp_overflow)
   );
endmodule

// ----- sv/dltq_checker.sv -----
// Port level checks of the timer queue and their binding to the top level.
`include "delta_list_timer_queue_top_defines.svh"

module dltq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic [dltq_pkg::KIND_W-1:0]   rsp_kind,
   input logic [dltq_pkg::TIME_W-1:0]   rsp_fire_time,
   input logic                          rsp_last,
   input logic                          rsp_overflow
);
   import dltq_pkg::*;

   `DLTQ_ASSERT_ALWAYS(a_reset_empties, reset |=> rsp_empty)
   `DLTQ_ASSERT(a_result_holds, !rsp_empty && !rsp_pop |=> !rsp_empty)
   `DLTQ_ASSERT(a_add_single, !rsp_empty && rsp_kind != KIND_FIRED |-> rsp_last && !rsp_overflow && rsp_fire_time == '0)
   `DLTQ_ASSERT(a_tick_consistent, !rsp_empty && rsp_pop && !rsp_last |=> rsp_empty || (rsp_kind == KIND_FIRED && rsp_overflow == $past(rsp_overflow) && rsp_fire_time == $past(rsp_fire_time)))
endmodule

bind delta_list_timer_queue_top dltq_checker u_dltq_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_kind      (rsp_kind),
   .rsp_fire_time (rsp_fire_time),
   .rsp_last      (rsp_last),
   .rsp_overflow  (rsp_overflow)
);
